[design/mdv_pkg.sv]
package mdv_pkg;

    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 11'd12;
    localparam logic [CFG_W-1:0] FRAME_COLS_RST = 11'd16;

    // region counters
    localparam int NUM_REGIONS = 4;
    localparam int CNT_W       = 21;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // vote thresholds: max >= area/VOTE_MIN_DIV, max-min >= area/VOTE_SPREAD_DIV
    localparam int VOTE_MIN_DIV    = 20;
    localparam int VOTE_SPREAD_DIV = 10;

    localparam int DIR_W = 3;

    // region of a pixel and voted direction share one code
    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_UP    = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_DOWN  = 3'd4
    } dir_t;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        dir_t region;
        logic start;
        logic last;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_level_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_SCAN,
        BK_DECIDE
    } bk_state_t;

endpackage

[design/mdv_front.sv]
module mdv_front #(
    parameter int MAX_ROWS = mdv_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mdv_pkg::DEF_MAX_COLS,
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pixel_on,
    input  logic                          s_frame_start,
    input  logic                          cfg_wr_en,
    input  logic [mdv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mdv_pkg::CFG_W-1:0]     cfg_wdata,
    input  mdv_pkg::q_level_t             q_level,
    output mdv_pkg::q_push_t              push,
    output logic [AW-1:0]                 area
);
    import mdv_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int PRW = $clog2(MAX_ROWS);
    localparam int PCW = $clog2(MAX_COLS);
    localparam int SW  = AW + 2;
    localparam int IFW = QCNT_W + 1;

    logic [CFG_W-1:0] frame_rows_reg, frame_cols_reg;
    logic [RW-1:0]    rows_eff;
    logic [CW-1:0]    cols_eff;
    logic [RW+CW-1:0] area_full;
    logic [AW-1:0]    area_reg;

    logic [PRW-1:0] row_reg, row_next, cur_i;
    logic [PCW-1:0] col_reg, col_next, cur_j;
    logic           col_end, row_end, frame_end, accept;

    // stage A: position of the accepted word
    logic           va_reg, a_on_reg, a_start_reg, a_last_reg;
    logic [PRW-1:0] a_i_reg;
    logic [PCW-1:0] a_j_reg;

    // stage B: cross products
    logic            vb_reg, b_on_reg, b_start_reg, b_last_reg;
    logic [AW-1:0]   b_rj_reg, b_ic_reg;
    logic [RW+PCW-1:0] rj_full;
    logic [PRW+CW-1:0] ic_full;

    logic signed [SW-1:0] rj_s, ic_s, cols_s, area_s, y_s;
    logic gt_d, lt_d, gt_e, lt_e;
    dir_t region;
    logic [IFW-1:0] inflight;

    // clamp sizes to 1..MAX
    assign rows_eff = (frame_rows_reg == '0) ? RW'(1) :
                      ((32'(frame_rows_reg) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) :
                       RW'(frame_rows_reg));
    assign cols_eff = (frame_cols_reg == '0) ? CW'(1) :
                      ((32'(frame_cols_reg) > 32'(MAX_COLS)) ? CW'(MAX_COLS) :
                       CW'(frame_cols_reg));
    assign area_full = rows_eff * cols_eff;
    assign area      = area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= FRAME_ROWS_RST;
            frame_cols_reg <= FRAME_COLS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_ROWS: frame_rows_reg <= cfg_wdata;
                REG_FRAME_COLS: frame_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        area_reg <= AW'(area_full);
    end

    // reserve a queue slot for every word in flight
    assign inflight = IFW'(q_level.count) + IFW'(va_reg) + IFW'(vb_reg);
    assign s_ready  = inflight < IFW'(QUEUE_DEPTH);
    assign accept   = s_valid && s_ready;

    // frame start restarts the position before this word is placed
    assign cur_i     = s_frame_start ? '0 : row_reg;
    assign cur_j     = s_frame_start ? '0 : col_reg;
    assign col_end   = (CW'(cur_j) + CW'(1)) >= cols_eff;
    assign row_end   = (RW'(cur_i) + RW'(1)) >= rows_eff;
    assign frame_end = col_end && row_end;

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept) begin
            if (frame_end) begin
                row_next = '0;
                col_next = '0;
            end else if (col_end) begin
                row_next = cur_i + PRW'(1);
                col_next = '0;
            end else begin
                row_next = cur_i;
                col_next = cur_j + PCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            va_reg  <= accept;
            vb_reg  <= va_reg;
        end
    end

    assign rj_full = rows_eff * a_j_reg;
    assign ic_full = a_i_reg * cols_eff;

    always_ff @(posedge aclk) begin
        a_i_reg     <= cur_i;
        a_j_reg     <= cur_j;
        a_on_reg    <= s_pixel_on;
        a_start_reg <= s_frame_start;
        a_last_reg  <= frame_end;
        b_rj_reg    <= AW'(rj_full);
        b_ic_reg    <= AW'(ic_full);
        b_on_reg    <= a_on_reg;
        b_start_reg <= a_start_reg;
        b_last_reg  <= a_last_reg;
    end

    // i vs d = floor(rows*j/cols) and e = rows-d, decided without a divider:
    // i > d <=> i*cols > rows*j, i < d <=> (i+1)*cols <= rows*j,
    // i > e <=> (rows-i+1)*cols <= rows*j, i < e <=> (rows-i)*cols > rows*j
    assign rj_s   = signed'(SW'(b_rj_reg));
    assign ic_s   = signed'(SW'(b_ic_reg));
    assign cols_s = signed'(SW'(cols_eff));
    assign area_s = signed'(SW'(area_reg));
    assign y_s    = area_s - ic_s;
    assign gt_d   = ic_s > rj_s;
    assign lt_d   = (ic_s + cols_s) <= rj_s;
    assign gt_e   = (y_s + cols_s) <= rj_s;
    assign lt_e   = y_s > rj_s;

    always_comb begin
        region = DIR_NONE;
        if (b_on_reg) begin
            if (gt_d && gt_e) begin
                region = DIR_DOWN;
            end else if (lt_d && gt_e) begin
                region = DIR_RIGHT;
            end else if (lt_d && lt_e) begin
                region = DIR_UP;
            end else if (gt_d && lt_e) begin
                region = DIR_LEFT;
            end
        end
    end

    assign push.valid        = vb_reg;
    assign push.entry.region = region;
    assign push.entry.start  = b_start_reg;
    assign push.entry.last   = b_last_reg;

endmodule

[design/mdv_queue.sv]
module mdv_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  mdv_pkg::q_push_t  push,
    input  logic              pop,
    output mdv_pkg::q_head_t  head,
    output mdv_pkg::q_level_t level
);
    import mdv_pkg::*;

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push.valid) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head.valid  = count_reg != '0;
    assign head.entry  = slot_reg[rd_ptr_reg];
    assign level.count = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (count_reg < QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0 && count_reg != QCNT_W'(QUEUE_DEPTH)) |->
            wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers disagree with fill level");

endmodule

[design/mdv_back.sv]
module mdv_back #(
    parameter int MAX_ROWS = mdv_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mdv_pkg::DEF_MAX_COLS,
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mdv_pkg::q_head_t          head,
    output logic                      pop,
    input  logic [AW-1:0]             area,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [mdv_pkg::DIR_W-1:0] m_direction
);
    import mdv_pkg::*;

    localparam int TW = (AW > CNT_W + 6) ? AW : CNT_W + 6;

    bk_state_t state_reg, state_next;
    logic      scan_en, decide_fire, out_free;

    logic [CNT_W-1:0] counts_reg [NUM_REGIONS];
    logic [CNT_W-1:0] counts_next [NUM_REGIONS];
    logic [1:0]       bump_idx;
    logic             bump_en;

    logic [CNT_W-1:0] mx, mn, mx_reg, mn_reg;
    dir_t             dir, dir_reg, voted;
    logic [TW-1:0]    mx_p1, spread_p1;
    logic             lo_ok, hi_ok;

    logic m_valid_reg;
    dir_t m_dir_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN: begin
                if (head.valid && head.entry.last) begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN: state_next = BK_DECIDE;
            BK_DECIDE: begin
                if (out_free) begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    always_comb begin
        pop         = 1'b0;
        scan_en     = 1'b0;
        decide_fire = 1'b0;
        case (state_reg)
            BK_RUN:    pop         = head.valid;
            BK_SCAN:   scan_en     = 1'b1;
            BK_DECIDE: decide_fire = out_free;
            default: ;
        endcase
    end

    always_comb begin
        bump_idx = 2'd0;
        bump_en  = 1'b0;
        case (head.entry.region)
            DIR_LEFT: begin
                bump_idx = 2'd0;
                bump_en  = 1'b1;
            end
            DIR_UP: begin
                bump_idx = 2'd1;
                bump_en  = 1'b1;
            end
            DIR_RIGHT: begin
                bump_idx = 2'd2;
                bump_en  = 1'b1;
            end
            DIR_DOWN: begin
                bump_idx = 2'd3;
                bump_en  = 1'b1;
            end
            default: ;
        endcase
    end

    // frame start clears before the word counts; saturate at the top
    always_comb begin
        counts_next = counts_reg;
        if (pop) begin
            if (head.entry.start) begin
                for (int k = 0; k < NUM_REGIONS; k++) begin
                    counts_next[k] = '0;
                end
            end
            if (bump_en && counts_next[bump_idx] != CNT_MAX) begin
                counts_next[bump_idx] = counts_next[bump_idx] + CNT_W'(1);
            end
        end else if (decide_fire) begin
            for (int k = 0; k < NUM_REGIONS; k++) begin
                counts_next[k] = '0;
            end
        end
    end

    // largest count, earlier region wins a tie
    always_comb begin
        mx  = counts_reg[0];
        mn  = counts_reg[0];
        dir = DIR_LEFT;
        for (int k = 1; k < NUM_REGIONS; k++) begin
            if (counts_reg[k] > mx) begin
                mx  = counts_reg[k];
                dir = dir_t'(DIR_W'(k + 1));
            end
            if (counts_reg[k] < mn) begin
                mn = counts_reg[k];
            end
        end
    end

    // x >= floor(A/n) <=> n*(x+1) > A
    assign mx_p1     = TW'(mx_reg) + TW'(1);
    assign spread_p1 = TW'(mx_reg - mn_reg) + TW'(1);
    assign lo_ok     = (mx_p1 * TW'(VOTE_MIN_DIV)) > TW'(area);
    assign hi_ok     = (spread_p1 * TW'(VOTE_SPREAD_DIV)) > TW'(area);
    assign voted     = (lo_ok && hi_ok) ? dir_reg : DIR_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_RUN;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_REGIONS; k++) begin
                counts_reg[k] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            counts_reg <= counts_next;
            if (decide_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_en) begin
            mx_reg  <= mx;
            mn_reg  <= mn;
            dir_reg <= dir;
        end
        if (decide_fire) begin
            m_dir_reg <= voted;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_direction = m_dir_reg;

    a_last_to_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.entry.last) |=> state_reg == BK_SCAN)
        else $error("last word did not start the vote");

    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == BK_DECIDE))
        else $error("result raised outside the decide step");

    a_hold_during_vote: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != BK_RUN) |-> !pop)
        else $error("queue popped while voting");

endmodule

[design/mask_diagonal_region_direction_vote_top.sv]
// Result path: the last pixel word of a frame passes stages A and B and the queue, then the
//   back end pops it, scans, decides and raises m_valid once the result register is free.
// Throughput: one pixel word per cycle within a frame while the queue has room, set by the
//   back end's single counter update; each frame adds the back end's scan and decide states,
//   which pop nothing, so a sustained stream stalls the input at each frame end.
// Reset: aresetn, synchronous, active low, clears position, counts, pipeline and queue,
//   and loads frame_rows = 12, frame_cols = 16.
module mask_diagonal_region_direction_vote_top #(
    parameter int MAX_ROWS = mdv_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mdv_pkg::DEF_MAX_COLS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pixel_on,
    input  logic                          s_frame_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mdv_pkg::DIR_W-1:0]     m_direction,
    input  logic                          cfg_wr_en,
    input  logic [mdv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mdv_pkg::CFG_W-1:0]     cfg_wdata
);
    import mdv_pkg::*;

    localparam int AW = $clog2(MAX_ROWS * MAX_COLS + 1);

    q_push_t       push;
    q_head_t       head;
    q_level_t      level;
    logic          pop;
    logic [AW-1:0] area;

    mdv_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_on    (s_pixel_on),
        .s_frame_start (s_frame_start),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .q_level       (level),
        .push          (push),
        .area          (area)
    );

    mdv_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .level   (level)
    );

    mdv_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .pop         (pop),
        .area        (area),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_direction (m_direction)
    );

endmodule

[tb/tb_mask_diagonal_region_direction_vote_top.sv]
`timescale 1ns / 100ps

module tb_mask_diagonal_region_direction_vote_top;
    import mdv_pkg::*;

    localparam int SETTLE_CYCLES = 32;

    typedef struct {
        logic pixel_on;
        logic frame_start;
    } pixel_word_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_pixel_on = 1'b0;
    logic s_frame_start = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DIR_W-1:0] m_direction;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_ROWS;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // shadow of the block: size registers, scan position, region counts
    logic [CFG_W-1:0] rows_reg = FRAME_ROWS_RST;
    logic [CFG_W-1:0] cols_reg = FRAME_COLS_RST;
    int row_pos = 0;
    int col_pos = 0;
    logic [CNT_W-1:0] vote_cnt [NUM_REGIONS] = '{default: '0};

    pixel_word_t pending_words[$];
    dir_t expected_dirs[$];
    int tx_idle_pct = 30;
    int rx_idle_pct = 47;
    int n_pushed = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_sizes = 0;
    int dir_seen [5] = '{default: 0};

    mask_diagonal_region_direction_vote_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_on    (s_pixel_on),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_direction   (m_direction),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int clamp_size(logic [CFG_W-1:0] v, int lim);
        int s;
        s = int'(v);
        if (s < 1) s = 1;
        if (s > lim) s = lim;
        return s;
    endfunction

    // region of pixel (i, j) as split by the two frame diagonals
    function automatic dir_t region_of(int i, int j, int rows, int cols);
        int d;
        int e;
        d = (rows * j) / cols;
        e = rows - d;
        if (i > d && i > e) return DIR_DOWN;
        if (i < d && i > e) return DIR_RIGHT;
        if (i < d && i < e) return DIR_UP;
        if (i > d && i < e) return DIR_LEFT;
        return DIR_NONE;
    endfunction

    task automatic clear_frame();
        row_pos = 0;
        col_pos = 0;
        foreach (vote_cnt[k]) vote_cnt[k] = '0;
    endtask

    // advance the shadow by one accepted word; queue the vote on the last pixel
    task automatic track_pixel(input logic pixel_on, input logic frame_start);
        int rows;
        int cols;
        int area;
        int mx;
        int mn;
        dir_t r;
        dir_t vote;
        rows = clamp_size(rows_reg, DEF_MAX_ROWS);
        cols = clamp_size(cols_reg, DEF_MAX_COLS);
        if (frame_start) clear_frame();
        if (pixel_on) begin
            r = region_of(row_pos, col_pos, rows, cols);
            if (r != DIR_NONE && vote_cnt[int'(r) - 1] != CNT_MAX)
                vote_cnt[int'(r) - 1] = vote_cnt[int'(r) - 1] + 1'b1;
        end
        if (col_pos + 1 >= cols && row_pos + 1 >= rows) begin
            mx = int'(vote_cnt[0]);
            mn = mx;
            vote = DIR_LEFT;
            for (int k = 1; k < NUM_REGIONS; k++) begin
                if (int'(vote_cnt[k]) > mx) begin
                    mx = int'(vote_cnt[k]);
                    vote = dir_t'(k + 1);
                end
                if (int'(vote_cnt[k]) < mn) mn = int'(vote_cnt[k]);
            end
            area = rows * cols;
            if (mx < area / VOTE_MIN_DIV || mx - mn < area / VOTE_SPREAD_DIV) vote = DIR_NONE;
            expected_dirs.insert(expected_dirs.size(), vote);
            clear_frame();
        end else if (col_pos + 1 >= cols) begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // driver: present queued words, idling at random between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_pixel(s_pixel_on, s_frame_start);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_pixel_on <= pending_words[0].pixel_on;
                    s_frame_start <= pending_words[0].frame_start;
                    pending_words.delete(0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each direction word with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_dirs.size() == 0) begin
                    $error("direction: none expected, got %0d", m_direction);
                    n_errors++;
                end else begin
                    if (m_direction !== expected_dirs[0]) begin
                        $error("direction: expected %0d, got %0d",
                               expected_dirs[0], m_direction);
                        n_errors++;
                    end
                    expected_dirs.delete(0);
                    n_checked++;
                end
                if (m_direction <= DIR_DOWN) dir_seen[m_direction]++;
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push_word(input logic pixel_on, input logic frame_start);
        pending_words.insert(pending_words.size(), '{pixel_on, frame_start});
        n_pushed++;
    endtask

    // raster frame, optionally cut short; pixels cluster in one region picked at random, or fill evenly
    task automatic queue_frame(int rows, int cols, int len, bit with_start);
        int hot_region;
        int fill_pct;
        dir_t r;
        hot_region = $urandom_range(0, 4);
        fill_pct = (hot_region == 0) ? $urandom_range(0, 100) : $urandom_range(0, 25);
        for (int k = 0; k < len; k++) begin
            r = region_of(k / cols, k % cols, rows, cols);
            if (hot_region != 0 && int'(r) == hot_region)
                push_word($urandom_range(99) < 85, with_start && k == 0);
            else
                push_word($urandom_range(99) < fill_pct, with_start && k == 0);
        end
    endtask

    task automatic fill_phase(int target);
        int rows;
        int cols;
        int area;
        int added;
        int kind;
        int len;
        added = 0;
        rows = clamp_size(rows_reg, DEF_MAX_ROWS);
        cols = clamp_size(cols_reg, DEF_MAX_COLS);
        area = rows * cols;
        while (added < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                len = area;
                queue_frame(rows, cols, len, $urandom_range(1) == 1);
            end else if (kind < 85) begin
                // truncated frame, restarted by the next frame start
                len = (area > 1) ? $urandom_range(1, area - 1) : 1;
                queue_frame(rows, cols, len, 1'b1);
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) push_word($urandom_range(1) == 1, $urandom_range(7) == 0);
            end
            added += len;
        end
    endtask

    task automatic wait_idle();
        while (n_accepted != n_pushed || expected_dirs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_ROWS;
        cfg_wdata <= rows;
        @(posedge aclk);
        cfg_index <= REG_FRAME_COLS;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rows_reg = rows;
        cols_reg = cols;
        n_sizes++;
    endtask

    initial begin
        int r;
        int c;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // part of a 12x16 frame at reset sizes, then shrink to 1x1 mid-frame
        push_word(1'b1, 1'b1);
        repeat (5) push_word(1'b1, 1'b0);
        wait_idle();
        set_frame_size(11'd0, 11'd0);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b1);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b0);
        wait_idle();

        // 2x2: full frame, wrap without frame start, cut frame and restart
        set_frame_size(11'd2, 11'd2);
        repeat (4) push_word(1'b1, 1'b0);
        push_word(1'b0, 1'b0);
        repeat (3) push_word(1'b1, 1'b0);
        push_word(1'b1, 1'b1);
        push_word(1'b1, 1'b0);
        push_word(1'b0, 1'b1);
        repeat (3) push_word(1'b1, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                tx_idle_pct = 47;
                rx_idle_pct = 30;
            end
            if (ph == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph == 2) begin
                // rows above the maximum clamp to it: walk down to row 3 one column wide,
                // then widen so that pixel (3,2) falls left only with clamped rows
                set_frame_size(11'd2047, 11'd1);
                push_word(1'b0, 1'b1);
                repeat (2) push_word(1'b0, 1'b0);
                wait_idle();
                set_frame_size(11'd2047, 11'd1024);
                repeat (2) push_word(1'b0, 1'b0);
                push_word(1'b1, 1'b0);
                push_word(1'b0, 1'b0);
                push_word(1'b1, 1'b0);
                wait_idle();
                // close the frame on the next pixel
                set_frame_size(11'd1, 11'd1);
                push_word(1'b0, 1'b0);
            end else if (ph == 6) begin
                // columns above the maximum clamp to it: pixel (0,1) falls up only then
                set_frame_size(11'd1024, 11'd2047);
                push_word(1'b1, 1'b1);
                push_word(1'b1, 1'b0);
                wait_idle();
                set_frame_size(11'd1, 11'd1);
                push_word(1'b0, 1'b0);
            end else begin
                r = ($urandom_range(4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                c = ($urandom_range(4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                // zero stands for one
                if (r == 1 && $urandom_range(1)) r = 0;
                if (c == 1 && $urandom_range(1)) c = 0;
                set_frame_size(r[CFG_W-1:0], c[CFG_W-1:0]);
                fill_phase(25);
            end
            wait_idle();
        end

        $display("Covered %0d pixel words over %0d frame sizes, %0d directions checked",
                 n_pushed, n_sizes, n_checked);
        $display("Directions seen: none %0d, left %0d, up %0d, right %0d, down %0d",
                 dir_seen[0], dir_seen[1], dir_seen[2], dir_seen[3], dir_seen[4]);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
design/mdv_pkg.sv
design/mdv_front.sv
design/mdv_queue.sv
design/mdv_back.sv
design/mask_diagonal_region_direction_vote_top.sv
tb/tb_mask_diagonal_region_direction_vote_top.sv
